@@ sv/cgcn_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the gripper command node.
// No dependencies; imported by can_gripper_command_node.
package cgcn_pkg;

	// heartbeat states and response codes
	localparam logic [7:0] HB_ALIVE  = 8'h05;
	localparam logic [7:0] HB_STOP   = 8'h00;
	localparam logic [7:0] ACK_CODE  = 8'h11;
	localparam logic [7:0] READ_RESP = 8'h21;

	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	// commanded modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_A    = 2'd1;
	localparam logic [1:0] MODE_B    = 2'd2;

	// frame length thresholds
	localparam logic [3:0] LEN_HB  = 4'd1;
	localparam logic [3:0] LEN_CMD = 4'd2;
	localparam logic [3:0] LEN_WR  = 4'd3;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TIMEOUT     = 3'd0,
		REG_CMD_ID      = 3'd1,
		REG_HB_ID       = 3'd2,
		REG_RESP_ID     = 3'd3,
		REG_WR_CODE     = 3'd4,
		REG_RD_CODE     = 3'd5,
		REG_RELAY_BANK  = 3'd6,
		REG_SENSOR_BANK = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [10:0] command_frame_id;
		logic [10:0] heartbeat_frame_id;
		logic [10:0] response_frame_id;
		logic [7:0]  write_request_code;
		logic [7:0]  read_request_code;
		logic [7:0]  relay_bank_code;
		logic [7:0]  sensor_bank_code;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		timeout_ticks:      16'd500,
		command_frame_id:   11'h210,
		heartbeat_frame_id: 11'h600,
		response_frame_id:  11'h310,
		write_request_code: 8'h10,
		read_request_code:  8'h20,
		relay_bank_code:    8'h00,
		sensor_bank_code:   8'h10
	};

endpackage

@@ sv/can_gripper_command_node.sv @@
`timescale 1ns / 1ps
// Gripper command node: frame/tick decode, watchdog and commanded modes.
// Depends on cgcn_pkg.

// Takes one word per clock (a millisecond tick or a received classic frame)
// and returns exactly one result word per input word: the word is captured in
// an input stage, decoded against the watchdog count and mode registers, and
// the result lands in an output register. Both stages advance independently,
// so a new word is taken every cycle while the output side keeps up; a stalled
// output holds one result and one pending input.
// Configuration registers are written through the cfg channel, which is always
// ready; write them only while the node is idle.
module can_gripper_command_node
	import cgcn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [10:0] frame_id,
	input  logic [3:0]  frame_length,
	input  logic [7:0]  byte0,
	input  logic [7:0]  byte1,
	input  logic [7:0]  byte2,
	input  logic        sensor_up,
	input  logic        sensor_down,
	input  logic        sensor_closed,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  vertical_state,
	output logic [1:0]  jaw_state,
	output logic        failsafe_applied,
	output logic        tx_valid,
	output logic [10:0] tx_id,
	output logic [7:0]  tx_byte0,
	output logic [7:0]  tx_byte1,
	output logic [7:0]  tx_byte2
);

	cfg_t        cfg_q;
	logic [15:0] elapsed_q;
	logic [1:0]  vertical_q;
	logic [1:0]  jaw_q;

	// input stage
	logic        valid_s1;
	logic        cmd_s1;
	logic [10:0] fid_s1;
	logic [3:0]  len_s1;
	logic [7:0]  b0_s1;
	logic [7:0]  b1_s1;
	logic [7:0]  b2_s1;
	logic [2:0]  sens_s1;

	// result stage
	logic        valid_s2;
	logic [1:0]  vert_s2;
	logic [1:0]  jaw_s2;
	logic        fs_s2;
	logic        tx_s2;
	logic [10:0] tx_id_s2;
	logic [7:0]  t0_s2;
	logic [7:0]  t1_s2;
	logic [7:0]  t2_s2;

	logic        adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TIMEOUT:     cfg_q.timeout_ticks      <= cfg_data;
				REG_CMD_ID:      cfg_q.command_frame_id   <= cfg_data[10:0];
				REG_HB_ID:       cfg_q.heartbeat_frame_id <= cfg_data[10:0];
				REG_RESP_ID:     cfg_q.response_frame_id  <= cfg_data[10:0];
				REG_WR_CODE:     cfg_q.write_request_code <= cfg_data[7:0];
				REG_RD_CODE:     cfg_q.read_request_code  <= cfg_data[7:0];
				REG_RELAY_BANK:  cfg_q.relay_bank_code    <= cfg_data[7:0];
				REG_SENSOR_BANK: cfg_q.sensor_bank_code   <= cfg_data[7:0];
			endcase
		end
	end

	// input stage capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd;
			fid_s1  <= frame_id;
			len_s1  <= frame_length;
			b0_s1   <= byte0;
			b1_s1   <= byte1;
			b2_s1   <= byte2;
			sens_s1 <= {sensor_closed, sensor_down, sensor_up};
		end
	end

	// decode
	logic [15:0] elapsed_inc;
	logic [15:0] elapsed_nxt;
	logic [1:0]  vert_nxt;
	logic [1:0]  jaw_nxt;
	logic        fs;
	logic        tx;
	logic [7:0]  t0;
	logic [7:0]  t1;
	logic [7:0]  t2;
	logic        wr_hit;
	logic        rd_hit;

	assign elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign wr_hit = (b0_s1 == cfg_q.write_request_code) && (b1_s1 == cfg_q.relay_bank_code);
	assign rd_hit = (b0_s1 == cfg_q.read_request_code) && (b1_s1 == cfg_q.sensor_bank_code);

	always_comb begin
		elapsed_nxt = elapsed_q;
		vert_nxt    = vertical_q;
		jaw_nxt     = jaw_q;
		fs          = 1'b0;
		tx          = 1'b0;
		t0          = '0;
		t1          = '0;
		t2          = '0;
		priority if (!cmd_s1) begin
			elapsed_nxt = elapsed_inc;
			fs          = (elapsed_inc >= cfg_q.timeout_ticks);
		end else if (fid_s1 == cfg_q.heartbeat_frame_id) begin
			if (len_s1 >= LEN_HB) begin
				if (b0_s1 == HB_ALIVE) begin
					elapsed_nxt = '0;
				end else if (b0_s1 == HB_STOP) begin
					fs = 1'b1;
				end
			end
		end else if (fid_s1 == cfg_q.command_frame_id) begin
			elapsed_nxt = '0;
			if (len_s1 >= LEN_CMD) begin
				if (wr_hit) begin
					if (len_s1 >= LEN_WR) begin
						// down overrides up, open overrides close
						if (b2_s1[1]) vert_nxt = MODE_B;
						else if (b2_s1[0]) vert_nxt = MODE_A;
						if (b2_s1[3]) jaw_nxt = MODE_B;
						else if (b2_s1[2]) jaw_nxt = MODE_A;
						tx = 1'b1;
						t0 = ACK_CODE;
						t1 = cfg_q.relay_bank_code;
						t2 = b2_s1;
					end
				end else if (rd_hit) begin
					tx = 1'b1;
					t0 = READ_RESP;
					t1 = cfg_q.sensor_bank_code;
					t2 = {5'd0, sens_s1};
				end
			end
		end else begin
			// frames with other ids are ignored
		end
		if (fs) begin
			vert_nxt = MODE_IDLE;
			jaw_nxt  = MODE_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= '0;
			vertical_q <= MODE_IDLE;
			jaw_q      <= MODE_IDLE;
		end else if (adv_s1) begin
			elapsed_q  <= elapsed_nxt;
			vertical_q <= vert_nxt;
			jaw_q      <= jaw_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			vert_s2  <= vert_nxt;
			jaw_s2   <= jaw_nxt;
			fs_s2    <= fs;
			tx_s2    <= tx;
			tx_id_s2 <= tx ? cfg_q.response_frame_id : 11'd0;
			t0_s2    <= t0;
			t1_s2    <= t1;
			t2_s2    <= t2;
		end
	end

	assign out_valid        = valid_s2;
	assign vertical_state   = vert_s2;
	assign jaw_state        = jaw_s2;
	assign failsafe_applied = fs_s2;
	assign tx_valid         = tx_s2;
	assign tx_id            = tx_id_s2;
	assign tx_byte0         = t0_s2;
	assign tx_byte1         = t1_s2;
	assign tx_byte2         = t2_s2;

`ifndef SYNTHESIS
	a_tx_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && tx_s2 |-> (t0_s2 == ACK_CODE || t0_s2 == READ_RESP))
		else $error("response with unknown code");

	a_fs_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && fs_s2 |-> (vert_s2 == MODE_IDLE && jaw_s2 == MODE_IDLE))
		else $error("failsafe result with non-idle modes");

	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(vertical_q) && $stable(jaw_q) && $stable(elapsed_q))
		else $error("state changed without an item");

	a_elapsed_step: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q != $past(elapsed_q) |->
			(elapsed_q == 16'd0 || elapsed_q == $past(elapsed_q) + 16'd1))
		else $error("watchdog count jumped");
`endif

endmodule
